/* hdl/obb2d_pkg.sv */
package obb2d_pkg;

   // Field widths of one beat.
   localparam int COORD_W = 24;
   localparam int ANG_W   = 16;
   localparam int EXT_W   = 23;

   localparam int DEF_ANGLE_BITS = 16;

   // Corner and edge coordinates, and projection products.
   localparam int CW = 26;
   localparam int PW = 56;

   // Pipeline depths of the parts.
   localparam int TRIG_LAT = 9;
   localparam int BOX_LAT  = TRIG_LAT + 3;
   localparam int PROJ_LAT = 3;
   localparam int TOTAL_LAT = BOX_LAT + PROJ_LAT;

   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

   // Exact reciprocals for 31-bit dividends: ceil(2^(31+l)/d), l = ceil(log2 d).
   localparam longint unsigned R42_L = ((64'd1 << 37) + 64'd41) / 64'd42;
   localparam longint unsigned R56_L = ((64'd1 << 37) + 64'd55) / 64'd56;
   localparam longint unsigned R20_L = ((64'd1 << 36) + 64'd19) / 64'd20;
   localparam longint unsigned R30_L = ((64'd1 << 36) + 64'd29) / 64'd30;
   localparam longint unsigned R6_L  = ((64'd1 << 34) + 64'd5) / 64'd6;
   localparam longint unsigned R12_L = ((64'd1 << 35) + 64'd11) / 64'd12;
   localparam logic [31:0] R42 = 32'(R42_L);
   localparam logic [31:0] R56 = 32'(R56_L);
   localparam logic [31:0] R20 = 32'(R20_L);
   localparam logic [31:0] R30 = 32'(R30_L);
   localparam logic [31:0] R6  = 32'(R6_L);
   localparam logic [31:0] R12 = 32'(R12_L);

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [PW-1:0] proj_type;

   typedef struct packed {
      logic signed [31:0] sin;
      logic signed [31:0] cos;
   } trig_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cz;
      logic [ANG_W-1:0]          angle;
      logic [EXT_W-1:0]          wid;
      logic [EXT_W-1:0]          len;
   } box_in_type;

   typedef struct packed {
      coord_type [3:0] x;
      coord_type [3:0] z;
      coord_type [1:0] ex;
      coord_type [1:0] ez;
      proj_type  [1:0] len2;
      proj_type  [1:0] org;
   } geom_type;

endpackage

/* hdl/obb2d_trig.sv */
module obb2d_trig #(
   parameter int ANGLE_BITS = obb2d_pkg::DEF_ANGLE_BITS
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [obb2d_pkg::ANG_W-1:0] angle,
   output obb2d_pkg::trig_type         trig
);
   import obb2d_pkg::*;

   logic [31:0] u;
   logic        swap;
   logic [29:0] r;
   logic [29:0] th_in;

   logic [29:0] th_ff [7];
   logic [29:0] t2_ff [6];
   logic [2:0]  qs_ff [8];
   logic [29:0] ds3_ff, dc3_ff, ms4_ff, mc4_ff, ds5_ff, dc5_ff;
   logic [29:0] ms6_ff, mc6_ff, ds7_ff, dc7_ff, s8_ff, mc8_ff;
   trig_type    trig_ff, trig_in;
   logic [30:0] s_full, c_full, s_sw, c_sw;

   // Fold the angle into the first octant of its quadrant.
   assign u     = 32'(angle) << (32 - ANGLE_BITS);
   assign swap  = u[29:0] > 30'h2000_0000;
   assign r     = swap ? 30'(31'h4000_0000 - {1'b0, u[29:0]}) : u[29:0];
   assign th_in = 30'((64'(r) * 64'(PI_HALF_Q30)) >> 30);

   always_ff @(posedge clock) begin
      if (adv) begin
         th_ff[0] <= th_in;
         qs_ff[0] <= {u[31:30], swap};
         for (int i = 1; i < 7; i++) th_ff[i] <= th_ff[i-1];
         for (int i = 1; i < 8; i++) qs_ff[i] <= qs_ff[i-1];
         t2_ff[0] <= 30'((64'(th_ff[0]) * 64'(th_ff[0])) >> 30);
         for (int i = 1; i < 6; i++) t2_ff[i] <= t2_ff[i-1];
         ds3_ff <= 30'((64'(t2_ff[0]) * 64'(R42)) >> 37);
         dc3_ff <= 30'((64'(t2_ff[0]) * 64'(R56)) >> 37);
         ms4_ff <= 30'((64'(t2_ff[1]) * 64'(Q30_ONE - 31'(ds3_ff))) >> 30);
         mc4_ff <= 30'((64'(t2_ff[1]) * 64'(Q30_ONE - 31'(dc3_ff))) >> 30);
         ds5_ff <= 30'((64'(ms4_ff) * 64'(R20)) >> 36);
         dc5_ff <= 30'((64'(mc4_ff) * 64'(R30)) >> 36);
         ms6_ff <= 30'((64'(t2_ff[3]) * 64'(Q30_ONE - 31'(ds5_ff))) >> 30);
         mc6_ff <= 30'((64'(t2_ff[3]) * 64'(Q30_ONE - 31'(dc5_ff))) >> 30);
         ds7_ff <= 30'((64'(ms6_ff) * 64'(R6)) >> 34);
         dc7_ff <= 30'((64'(mc6_ff) * 64'(R12)) >> 35);
         s8_ff  <= 30'((64'(th_ff[6]) * 64'(Q30_ONE - 31'(ds7_ff))) >> 30);
         mc8_ff <= 30'((64'(t2_ff[5]) * 64'(Q30_ONE - 31'(dc7_ff))) >> 30);
         trig_ff <= trig_in;
      end
   end

   always_comb begin
      s_full = 31'(s8_ff);
      c_full = Q30_ONE - 31'(mc8_ff >> 1);
      s_sw   = qs_ff[7][0] ? c_full : s_full;
      c_sw   = qs_ff[7][0] ? s_full : c_full;
      case (qs_ff[7][2:1])
         2'd0: begin
            trig_in.sin = 32'(s_sw);
            trig_in.cos = 32'(c_sw);
         end
         2'd1: begin
            trig_in.sin = 32'(c_sw);
            trig_in.cos = -32'(s_sw);
         end
         2'd2: begin
            trig_in.sin = -32'(s_sw);
            trig_in.cos = -32'(c_sw);
         end
         default: begin
            trig_in.sin = -32'(c_sw);
            trig_in.cos = 32'(s_sw);
         end
      endcase
   end

   assign trig = trig_ff;

endmodule

/* hdl/obb2d_box.sv */
module obb2d_box #(
   parameter int ANGLE_BITS = obb2d_pkg::DEF_ANGLE_BITS
) (
   input  logic                  clock,
   input  logic                  adv,
   input  obb2d_pkg::box_in_type box,
   output obb2d_pkg::geom_type   geom
);
   import obb2d_pkg::*;

   trig_type   trig;
   box_in_type dly_ff [TRIG_LAT];
   logic [53:0] pr_ff [4];
   logic        cneg_ff, sneg_ff;
   logic signed [COORD_W-1:0] cx_ff, cz_ff;
   logic [30:0] cmag, smag;
   logic [22:0] v [4];
   coord_type   hxx, hxz, hzx, hzz, cx, cz;
   geom_type    mid_ff, mid_in, geom_ff;

   obb2d_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
      .clock (clock),
      .adv   (adv),
      .angle (box.angle),
      .trig  (trig)
   );

   assign cmag = 31'(trig.cos < 0 ? -trig.cos : trig.cos);
   assign smag = 31'(trig.sin < 0 ? -trig.sin : trig.sin);

   always_comb begin
      for (int k = 0; k < 4; k++) v[k] = 23'((pr_ff[k] + 54'(64'd1 << 30)) >> 31);
      hxx = cneg_ff ? -coord_type'(v[0]) : coord_type'(v[0]);
      hxz = sneg_ff ? -coord_type'(v[1]) : coord_type'(v[1]);
      hzx = sneg_ff ? coord_type'(v[2]) : -coord_type'(v[2]);
      hzz = cneg_ff ? -coord_type'(v[3]) : coord_type'(v[3]);
      cx  = coord_type'(cx_ff);
      cz  = coord_type'(cz_ff);
      mid_in      = '0;
      mid_in.x[0] = cx - hxx - hzx;
      mid_in.x[1] = cx + hxx - hzx;
      mid_in.x[2] = cx + hxx + hzx;
      mid_in.x[3] = cx - hxx + hzx;
      mid_in.z[0] = cz - hxz - hzz;
      mid_in.z[1] = cz + hxz - hzz;
      mid_in.z[2] = cz + hxz + hzz;
      mid_in.z[3] = cz - hxz + hzz;
      mid_in.ex[0] = hxx <<< 1;
      mid_in.ez[0] = hxz <<< 1;
      mid_in.ex[1] = hzx <<< 1;
      mid_in.ez[1] = hzz <<< 1;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= box;
         for (int i = 1; i < TRIG_LAT; i++) dly_ff[i] <= dly_ff[i-1];
         pr_ff[0] <= 54'(dly_ff[TRIG_LAT-1].wid) * 54'(cmag);
         pr_ff[1] <= 54'(dly_ff[TRIG_LAT-1].wid) * 54'(smag);
         pr_ff[2] <= 54'(dly_ff[TRIG_LAT-1].len) * 54'(smag);
         pr_ff[3] <= 54'(dly_ff[TRIG_LAT-1].len) * 54'(cmag);
         cneg_ff  <= trig.cos < 0;
         sneg_ff  <= trig.sin < 0;
         cx_ff    <= dly_ff[TRIG_LAT-1].cx;
         cz_ff    <= dly_ff[TRIG_LAT-1].cz;
         mid_ff   <= mid_in;
         geom_ff.x  <= mid_ff.x;
         geom_ff.z  <= mid_ff.z;
         geom_ff.ex <= mid_ff.ex;
         geom_ff.ez <= mid_ff.ez;
         for (int i = 0; i < 2; i++) begin
            geom_ff.len2[i] <= proj_type'(mid_ff.ex[i]) * proj_type'(mid_ff.ex[i])
                             + proj_type'(mid_ff.ez[i]) * proj_type'(mid_ff.ez[i]);
            geom_ff.org[i]  <= proj_type'(mid_ff.x[0]) * proj_type'(mid_ff.ex[i])
                             + proj_type'(mid_ff.z[0]) * proj_type'(mid_ff.ez[i]);
         end
      end
   end

   assign geom = geom_ff;

endmodule

/* hdl/obb2d_proj.sv */
module obb2d_proj (
   input  logic                       clock,
   input  logic                       adv,
   input  obb2d_pkg::coord_type       ax_x,
   input  obb2d_pkg::coord_type       ax_z,
   input  obb2d_pkg::proj_type        len2,
   input  obb2d_pkg::proj_type        org,
   input  obb2d_pkg::coord_type [3:0] qx,
   input  obb2d_pkg::coord_type [3:0] qz,
   output logic                       sep
);
   import obb2d_pkg::*;

   proj_type px_ff [4];
   proj_type pz_ff [4];
   proj_type t_ff [4];
   proj_type len2_ff [2];
   proj_type org_ff [2];
   proj_type lo01, lo23, hi01, hi23, lo, hi;
   logic     sep_ff, sep_in;

   always_comb begin
      lo01 = (t_ff[1] < t_ff[0]) ? t_ff[1] : t_ff[0];
      hi01 = (t_ff[1] > t_ff[0]) ? t_ff[1] : t_ff[0];
      lo23 = (t_ff[3] < t_ff[2]) ? t_ff[3] : t_ff[2];
      hi23 = (t_ff[3] > t_ff[2]) ? t_ff[3] : t_ff[2];
      lo   = (lo23 < lo01) ? lo23 : lo01;
      hi   = (hi23 > hi01) ? hi23 : hi01;
      sep_in = (lo > len2_ff[1] + org_ff[1]) || (hi < org_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            px_ff[k] <= proj_type'(qx[k]) * proj_type'(ax_x);
            pz_ff[k] <= proj_type'(qz[k]) * proj_type'(ax_z);
            t_ff[k]  <= px_ff[k] + pz_ff[k];
         end
         len2_ff[0] <= len2;
         len2_ff[1] <= len2_ff[0];
         org_ff[0]  <= org;
         org_ff[1]  <= org_ff[0];
         sep_ff     <= sep_in;
      end
   end

   assign sep = sep_ff;

endmodule

/* hdl/obb2d_overlap_test_top.sv */
// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_ready    two boxes and b_collidable
// rsp_      out        rsp_valid / rsp_ready    boxes_overlap
//
// One beat is taken per cycle and one result beat leaves per cycle when
// the consumer keeps up. A request beat passes through sine and cosine,
// corner and axis setup, projection and span compare, and the output
// register before its result appears.
// Reset clears only the valid flags; the data stages need no reset.
// A stalled result holds the whole pipeline, so req_ready is low exactly
// when a result waits in the output register and rsp_ready is low.
module obb2d_overlap_test_top #(
   parameter int ANGLE_BITS = obb2d_pkg::DEF_ANGLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [obb2d_pkg::COORD_W-1:0] req_a_center_x,
   input  logic signed [obb2d_pkg::COORD_W-1:0] req_a_center_z,
   input  logic [obb2d_pkg::ANG_W-1:0]         req_a_angle,
   input  logic [obb2d_pkg::EXT_W-1:0]         req_a_width,
   input  logic [obb2d_pkg::EXT_W-1:0]         req_a_length,
   input  logic signed [obb2d_pkg::COORD_W-1:0] req_b_center_x,
   input  logic signed [obb2d_pkg::COORD_W-1:0] req_b_center_z,
   input  logic [obb2d_pkg::ANG_W-1:0]         req_b_angle,
   input  logic [obb2d_pkg::EXT_W-1:0]         req_b_width,
   input  logic [obb2d_pkg::EXT_W-1:0]         req_b_length,
   input  logic                                req_b_collidable,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_boxes_overlap
);
   import obb2d_pkg::*;

   logic       adv;
   box_in_type box_a, box_b;
   geom_type   geom_a, geom_b;
   logic [3:0] sep;

   // Valid and collidable flags travel alongside the data stages.
   logic [TOTAL_LAT-1:0] vld_ff, vld_in;
   logic [TOTAL_LAT-1:0] coll_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 overlap_ff;

   // The pipeline moves whenever the output register is free or drains.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   assign box_a = '{cx: req_a_center_x, cz: req_a_center_z, angle: req_a_angle,
                    wid: req_a_width, len: req_a_length};
   assign box_b = '{cx: req_b_center_x, cz: req_b_center_z, angle: req_b_angle,
                    wid: req_b_width, len: req_b_length};

   // Two box lanes build corners, axes and spans side by side.
   obb2d_box #(.ANGLE_BITS(ANGLE_BITS)) u_box_a (
      .clock (clock), .adv (adv), .box (box_a), .geom (geom_a)
   );
   obb2d_box #(.ANGLE_BITS(ANGLE_BITS)) u_box_b (
      .clock (clock), .adv (adv), .box (box_b), .geom (geom_b)
   );

   // Four axis lanes: both axes of A against B's corners, and the reverse.
   for (genvar i = 0; i < 2; i++) begin : g_axis
      obb2d_proj u_proj_a (
         .clock (clock), .adv (adv),
         .ax_x (geom_a.ex[i]), .ax_z (geom_a.ez[i]),
         .len2 (geom_a.len2[i]), .org (geom_a.org[i]),
         .qx (geom_b.x), .qz (geom_b.z),
         .sep (sep[i])
      );
      obb2d_proj u_proj_b (
         .clock (clock), .adv (adv),
         .ax_x (geom_b.ex[i]), .ax_z (geom_b.ez[i]),
         .len2 (geom_b.len2[i]), .org (geom_b.org[i]),
         .qx (geom_a.x), .qz (geom_a.z),
         .sep (sep[i+2])
      );
   end

   always_comb begin
      vld_in       = {vld_ff[TOTAL_LAT-2:0], req_valid};
      rsp_valid_in = vld_ff[TOTAL_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Merge: the boxes overlap only if no axis separates them and B collides.
   always_ff @(posedge clock) begin
      if (adv) begin
         coll_ff    <= {coll_ff[TOTAL_LAT-2:0], req_b_collidable};
         overlap_ff <= coll_ff[TOTAL_LAT-1] && (sep == 4'b0000);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_boxes_overlap = overlap_ff;

endmodule
